FILE: rtl/eslp_pkg.sv
// constants, widths and opcode codes for the envelope-swept two-pole lowpass
// depends on nothing; used by envelope_swept_two_pole_lowpass_top
package eslp_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int STEP_SHIFT  = 6;
  localparam int COEF_FRAC   = 16;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = COEF_FRAC + 2;
  localparam int IDX_W       = 10;
  localparam int OP_W        = 2;
  localparam int ENV_W       = 16;

  // unity term minus two coefficients needs two more bits than a coefficient
  localparam int C_W     = COEF_W + 2;
  localparam int PAB_W   = COEF_W + SAMPLE_W;
  localparam int PC_W    = C_W + SAMPLE_W;
  localparam int ACC_W   = PC_W + 2;
  localparam int SH_W    = ACC_W - COEF_FRAC;

  localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_WRITE   = 2'd2
  } opcode_t;

endpackage

FILE: rtl/envelope_swept_two_pole_lowpass_top.sv
// envelope-swept two-pole lowpass: coefficient memory, filter pipeline, output buffer
// depends on eslp_pkg
//
// channel  direction  fields                                              transaction
// in_      input      opcode, sample_in, entry_index, coef_a_in, coef_b_in  in_valid & in_ready
// out_     output     sample_out                                          out_valid & out_ready
//
// a sample passes from acceptance to the output buffer through coefficient read,
// then multiply, then sum and saturate; the feedback through the history registers
// holds a new sample back while the previous one is still in the multiply step
// note-on and table writes are accepted in any cycle
// a two-entry output buffer holds results; samples wait while it could overflow
// synchronous active-low reset clears control and history; the table is not cleared
module envelope_swept_two_pole_lowpass_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [eslp_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [eslp_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [eslp_pkg::IDX_W-1:0]          in_entry_index,
  input  logic signed [eslp_pkg::COEF_W-1:0]  in_coef_a_in,
  input  logic signed [eslp_pkg::COEF_W-1:0]  in_coef_b_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [eslp_pkg::SAMPLE_W-1:0] out_sample_out
);

  localparam int ADDR_W   = eslp_pkg::ADDR_W;
  localparam int COEF_W   = eslp_pkg::COEF_W;
  localparam int SAMPLE_W = eslp_pkg::SAMPLE_W;
  localparam int ENV_W    = eslp_pkg::ENV_W;
  localparam int C_W      = eslp_pkg::C_W;
  localparam int PAB_W    = eslp_pkg::PAB_W;
  localparam int PC_W     = eslp_pkg::PC_W;
  localparam int ACC_W    = eslp_pkg::ACC_W;
  localparam int SH_W     = eslp_pkg::SH_W;
  localparam int FRAC     = eslp_pkg::COEF_FRAC;

  localparam logic signed [C_W-1:0] UNITY = C_W'(2 ** FRAC);
  localparam logic [ENV_W-1:0] LAST_POS = ENV_W'(eslp_pkg::TABLE_DEPTH - 1);
  localparam logic signed [SAMPLE_W-1:0] SAT_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic [2*COEF_W-1:0] coef_mem [eslp_pkg::TABLE_DEPTH];
  logic [2*COEF_W-1:0] rdata_r;

  logic [ENV_W-1:0]          env_r;
  logic                      s1_valid_r;
  logic                      s2_valid_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] h1_r;
  logic signed [SAMPLE_W-1:0] h2_r;
  logic signed [PAB_W-1:0]   pa_r;
  logic signed [PAB_W-1:0]   pb_r;
  logic signed [PC_W-1:0]    pc_r;

  logic signed [SAMPLE_W-1:0] obuf_r [2];
  logic                      wr_ptr_r;
  logic                      rd_ptr_r;
  logic [1:0]                cnt_r;

  logic                      accept;
  logic                      take_sample;
  logic                      take_note;
  logic                      take_write;
  logic                      sample_ok;
  logic                      pop;
  logic [ENV_W-1:0]          pos_full;
  logic [ADDR_W-1:0]         rd_addr;
  logic [ADDR_W-1:0]         wr_addr;
  logic                      idx_ok;

  logic signed [COEF_W-1:0]  coef_a;
  logic signed [COEF_W-1:0]  coef_b;
  logic signed [C_W-1:0]     coef_c;
  logic signed [PAB_W-1:0]   pa_nxt;
  logic signed [PAB_W-1:0]   pb_nxt;
  logic signed [PC_W-1:0]    pc_nxt;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SH_W-1:0]    shv;
  logic signed [SAMPLE_W-1:0] y;

  // control
  assign sample_ok = !s1_valid_r && (({1'b0, s2_valid_r} + cnt_r) < 2'd2);

  always_comb begin
    case (eslp_pkg::opcode_t'(in_opcode))
      eslp_pkg::OP_SAMPLE: in_ready = sample_ok;
      default:             in_ready = 1'b1;
    endcase
  end

  assign accept      = in_valid && in_ready;
  assign take_sample = accept && (in_opcode == eslp_pkg::OP_SAMPLE);
  assign take_note   = accept && (in_opcode == eslp_pkg::OP_NOTE_ON);
  assign take_write  = accept && (in_opcode == eslp_pkg::OP_WRITE);

  assign pos_full = env_r >> eslp_pkg::STEP_SHIFT;
  assign rd_addr  = (pos_full > LAST_POS) ? ADDR_W'(LAST_POS) : ADDR_W'(pos_full);
  assign wr_addr  = ADDR_W'(in_entry_index);
  assign idx_ok   = 32'(in_entry_index) < eslp_pkg::TABLE_DEPTH;

  // coefficient memory, a in the upper half
  always_ff @(posedge clk) begin
    if (take_write && idx_ok) begin
      coef_mem[wr_addr] <= {in_coef_a_in, in_coef_b_in};
    end
    if (take_sample) begin
      rdata_r <= coef_mem[rd_addr];
    end
  end

  // multiply stage
  always_comb begin
    coef_a = $signed(rdata_r[2*COEF_W-1:COEF_W]);
    coef_b = $signed(rdata_r[COEF_W-1:0]);
    coef_c = UNITY - C_W'(coef_a) - C_W'(coef_b);
    pa_nxt = coef_a * h1_r;
    pb_nxt = coef_b * h2_r;
    pc_nxt = coef_c * x_r;
  end

  // sum, floor shift and saturate
  always_comb begin
    acc = ACC_W'(pa_r) + ACC_W'(pb_r) + ACC_W'(pc_r);
    shv = $signed(acc[ACC_W-1:FRAC]);
    if (shv > SH_W'(SAT_HI)) begin
      y = SAT_HI;
    end else if (shv < SH_W'(SAT_LO)) begin
      y = SAT_LO;
    end else begin
      y = SAMPLE_W'(shv);
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      x_r <= in_sample_in;
    end
    if (s1_valid_r) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      h1_r       <= '0;
      h2_r       <= '0;
    end else begin
      s1_valid_r <= take_sample;
      s2_valid_r <= s1_valid_r;
      if (take_note) begin
        env_r <= '0;
      end else if (take_sample && (env_r != eslp_pkg::ENV_MAX)) begin
        env_r <= env_r + ENV_W'(1);
      end
      if (s2_valid_r) begin
        h2_r <= h1_r;
        h1_r <= y;
      end
    end
  end

  // output buffer
  assign pop            = (cnt_r != 2'd0) && out_ready;
  assign out_valid      = cnt_r != 2'd0;
  assign out_sample_out = obuf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      obuf_r[wr_ptr_r] <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (s2_valid_r) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({s2_valid_r, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
